@@ src/bfssr_pkg.sv @@
// Shared types and constants for the burst-fire relay pattern controller.
`timescale 1ns / 1ps
package bfssr_pkg;

    localparam logic [1:0] CMD_SET_POWER = 2'd0;
    localparam logic [1:0] CMD_TICK      = 2'd1;
    localparam logic [1:0] CMD_ON        = 2'd2;
    localparam logic [1:0] CMD_OFF       = 2'd3;

    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_POWER_FIRST   = 3'd1;
    localparam logic [2:0] REG_POWER_LAST    = 3'd4;

    localparam int ACC_W = 24;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch request, clear channel index and done flag
        logic ch_begin;  // evaluate the current channel (fit or partial)
        logic div_step;  // one restoring division step for n
        logic fix_n;     // apply accumulator correction
        logic pat_step;  // one pattern-build step
        logic ch_next;   // commit pattern, advance channel index
    } bfssr_cmd_t;

    typedef struct packed {
        logic last_ch;   // no channel left after this one
        logic partial;   // current channel is the partial one
        logic div_done;
        logic pat_done;
    } bfssr_sts_t;

endpackage

@@ src/bfssr_ctrl.sv @@
// Controller state machine sequencing a set_power transfer through the datapath.
`timescale 1ns / 1ps
module bfssr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    output logic                  busy,
    output bfssr_pkg::bfssr_cmd_t cmd,
    input  bfssr_pkg::bfssr_sts_t sts
);
    import bfssr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CH    = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_FIX   = 6'b001000,
        ST_PAT   = 6'b010000,
        ST_NEXT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (go) begin
                    cmd.start = 1'b1;
                    state_next = ST_CH;
                end
            end
            ST_CH: begin
                cmd.ch_begin = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!sts.partial) begin
                    state_next = ST_NEXT;
                end else if (sts.div_done) begin
                    state_next = ST_FIX;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_FIX: begin
                cmd.fix_n = 1'b1;
                state_next = ST_PAT;
            end
            ST_PAT: begin
                if (sts.pat_done) begin
                    state_next = ST_NEXT;
                end else begin
                    cmd.pat_step = 1'b1;
                end
            end
            ST_NEXT: begin
                cmd.ch_next = 1'b1;
                state_next = sts.last_ch ? ST_IDLE : ST_CH;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ src/bfssr_datapath.sv @@
// Datapath: channel registers, allocation arithmetic, pattern builder and tick logic.
`timescale 1ns / 1ps
module bfssr_datapath #(
    parameter int HALF_PERIODS_PER_CYCLE = 32,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_wr_index,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  item_go,
    input  logic [1:0]            item_command,
    input  logic [19:0]           item_power_request,
    input  bfssr_pkg::bfssr_cmd_t cmd,
    output bfssr_pkg::bfssr_sts_t sts,
    output logic [3:0]            tick_levels,
    output logic [5:0]            tick_position
);
    import bfssr_pkg::*;

    localparam int D      = HALF_PERIODS_PER_CYCLE;
    localparam int PB     = 2 * D;
    localparam int CHL    = (MAX_CHANNELS < 4) ? MAX_CHANNELS : 4;
    localparam int PW     = $clog2(PB);
    localparam int DW     = $clog2(D + 1);
    localparam int SW     = $clog2(D + 1) + 1;   // gap sum, below D + pulses
    localparam int GW     = $clog2(PB);
    localparam int CW     = (CHL > 1) ? $clog2(CHL) : 1;
    localparam int NUM_W  = 36;                  // 2*D*R + 16*P
    localparam int DEN_W  = 22;                  // 32*P
    localparam int DIV_IT = DW + 1;
    localparam int DCW    = $clog2(DIV_IT + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(PB - 1);
    localparam logic signed [ACC_W+1:0] ACC_MAXV = (ACC_W+2)'(23'h7FFFFF);
    localparam logic signed [ACC_W+1:0] ACC_MINV = -(ACC_W+2)'(24'h800000);

    logic [2:0]       count_reg;
    logic [15:0]      power_reg [4];
    logic [PB-1:0]    active_reg [4];
    logic [PB-1:0]    pending_reg [4];
    logic             pflag_reg;
    logic [PW-1:0]    cyc_reg;
    logic             run_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [3:0]       lev_reg;

    // allocation working registers
    logic [20:0]      rest_reg;
    logic [2:0]       ch_reg;
    logic             done_reg;
    logic             partial_reg;
    logic [PB-1:0]    work_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DW-1:0]    quo_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [DW-1:0]    n_reg;
    logic [DW-1:0]    pulses_reg;
    logic [DW-1:0]    pcnt_reg;
    logic [DW-1:0]    off_reg;
    logic [SW-1:0]    sum_reg;
    logic [GW-1:0]    gap_reg;
    logic [PW:0]      pos_reg;
    logic             odd_reg;
    logic [1:0]       gsub_reg;   // gap division progress within a pulse
    logic             pat_fin_reg;

    logic [15:0] cur_p;
    logic [20:0] p16;
    assign cur_p = power_reg[ch_reg[1:0]];
    assign p16   = {1'b0, cur_p, 4'b0};

    function automatic logic [PB-1:0] set_bit(input logic [PB-1:0] w, input logic [PW:0] idx);
        logic [PB-1:0] r;
        r = w;
        if (idx < (PW+1)'(PB)) begin
            r[idx[PW-1:0]] = 1'b1;
        end
        return r;
    endfunction

    // restoring division step
    logic [NUM_W-1:0] den_shift;
    logic             div_ge;
    assign den_shift = NUM_W'(den_reg) << (DIV_IT - 1 - int'(dcnt_reg));
    assign div_ge    = rem_reg >= den_shift;

    // accumulator correction
    logic signed [ACC_W+1:0] acc_sum, acc_sat, qv, acc_fix;
    logic [DW-1:0]           n_fix;
    logic [ACC_W-1:0]        qbase;
    always_comb begin
        acc_sum = (ACC_W+2)'(acc_reg)
                + $signed({5'b0, rest_reg} * (ACC_W+2)'(D))
                - $signed((ACC_W+2)'(quo_reg) * (ACC_W+2)'(p16));
        acc_sat = (acc_sum > ACC_MAXV) ? ACC_MAXV : ((acc_sum < ACC_MINV) ? ACC_MINV : acc_sum);
        qbase   = ACC_W'(cur_p / 16'(D)) * ACC_W'(16 * D);
        qv      = $signed({2'b0, qbase});
        n_fix   = quo_reg;
        acc_fix = acc_sat;
        if (acc_sat >= qv) begin
            if (quo_reg < DW'(D)) begin
                n_fix = quo_reg + 1'b1;
                acc_fix = acc_sat - qv;
            end
        end else if (acc_sat <= -qv) begin
            if (quo_reg != '0) begin
                n_fix = quo_reg - 1'b1;
                acc_fix = acc_sat + qv;
            end
        end
        if (acc_fix > ACC_MAXV) acc_fix = ACC_MAXV;
        if (acc_fix < ACC_MINV) acc_fix = ACC_MINV;
    end

    logic [SW-1:0] sum_add;
    assign sum_add = sum_reg + SW'(off_reg);

    assign sts.last_ch  = (ch_reg + 3'd1 >= count_reg);
    assign sts.partial  = partial_reg;
    assign sts.div_done = (dcnt_reg == DCW'(DIV_IT));
    assign sts.pat_done = pat_fin_reg;

    logic [3:0] lev_c;
    logic [PW-1:0] cyc_c;
    logic tick_load;
    assign tick_load = run_reg && pflag_reg && (cyc_reg == LAST_POS);
    always_comb begin
        cyc_c = cyc_reg;
        if (tick_load) begin
            cyc_c = '0;
        end else if (run_reg && cyc_reg < LAST_POS) begin
            cyc_c = cyc_reg + 1'b1;
        end
        lev_c = '0;
        for (int i = 0; i < CHL; i++) begin
            if (run_reg && 3'(i) < count_reg) begin
                lev_c[i] = tick_load ? pending_reg[i][cyc_c] : active_reg[i][cyc_c];
            end
        end
    end

    assign tick_levels   = lev_reg;
    assign tick_position = 6'(cyc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd1;
            pflag_reg <= 1'b0;
            cyc_reg   <= '0;
            run_reg   <= 1'b0;
            acc_reg   <= '0;
            lev_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                power_reg[i]   <= '0;
                active_reg[i]  <= '0;
                pending_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_CHANNEL_COUNT) begin
                    if (cfg_wr_data[2:0] >= 3'd1 && cfg_wr_data[2:0] <= 3'(CHL)
                        && cfg_wr_data[2:0] != count_reg) begin
                        count_reg <= cfg_wr_data[2:0];
                        for (int i = 0; i < 4; i++) begin
                            power_reg[i]   <= '0;
                            active_reg[i]  <= '0;
                            pending_reg[i] <= '0;
                        end
                    end
                end else if (cfg_wr_index >= REG_POWER_FIRST && cfg_wr_index <= REG_POWER_LAST) begin
                    if (cfg_wr_index - 3'd1 < count_reg) begin
                        power_reg[2'(cfg_wr_index - 3'd1)] <= cfg_wr_data;
                    end
                end
            end
            if (item_go) begin
                unique case (item_command)
                    CMD_ON: begin
                        run_reg <= 1'b1;
                        cyc_reg <= LAST_POS;
                    end
                    CMD_OFF: begin
                        run_reg <= 1'b0;
                        cyc_reg <= '0;
                        for (int i = 0; i < 4; i++) begin
                            if (3'(i) < count_reg) active_reg[i] <= '0;
                        end
                    end
                    CMD_TICK: begin
                        cyc_reg <= cyc_c;
                        lev_reg <= lev_c;
                        if (tick_load) begin
                            pflag_reg <= 1'b0;
                            for (int i = 0; i < 4; i++) begin
                                if (3'(i) < count_reg) active_reg[i] <= pending_reg[i];
                            end
                        end
                    end
                    CMD_SET_POWER: pflag_reg <= 1'b1;
                    default: ;
                endcase
            end
            if (cmd.fix_n) begin
                acc_reg <= ACC_W'(acc_fix);
            end
            if (cmd.ch_next) begin
                pending_reg[ch_reg[1:0]] <= work_reg;
            end
        end
    end

    // allocation sequence registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rest_reg <= {1'b0, item_power_request};
            ch_reg   <= '0;
            done_reg <= 1'b0;
        end
        if (cmd.ch_begin) begin
            work_reg    <= '0;
            partial_reg <= 1'b0;
            if (!done_reg) begin
                if (rest_reg >= p16) begin
                    work_reg <= '1;
                    rest_reg <= rest_reg - p16;
                end else begin
                    partial_reg <= 1'b1;
                    rem_reg  <= NUM_W'(rest_reg) * NUM_W'(2 * D) + NUM_W'(p16);
                    den_reg  <= {p16, 1'b0};
                    quo_reg  <= '0;
                    dcnt_reg <= '0;
                end
            end
        end
        if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 1'b1;
            quo_reg  <= {quo_reg[DW-2:0], div_ge};
            if (div_ge) rem_reg <= rem_reg - den_shift;
        end
        if (cmd.fix_n) begin
            done_reg    <= 1'b1;
            n_reg       <= n_fix;
            pulses_reg  <= n_fix >> 1;
            pcnt_reg    <= '0;
            off_reg     <= DW'(D) - n_fix;
            sum_reg     <= '0;
            gap_reg     <= GW'(PB - 2);
            pos_reg     <= '0;
            odd_reg     <= n_fix[0];
            gsub_reg    <= '0;
            pat_fin_reg <= 1'b0;
            if (n_fix >= DW'(D)) begin
                work_reg    <= '1;
                pat_fin_reg <= 1'b1;
            end
        end
        if (cmd.pat_step) begin
            if (pcnt_reg < pulses_reg) begin
                if (gsub_reg == 2'd0) begin
                    work_reg <= set_bit(set_bit(set_bit(work_reg, pos_reg),
                                pos_reg + 1'b1), pos_reg + 2'd2);
                    if (sum_add < SW'(pulses_reg)) begin
                        work_reg <= set_bit(set_bit(set_bit(set_bit(work_reg, pos_reg),
                                    pos_reg + 1'b1), pos_reg + 2'd2), pos_reg + 2'd3);
                        pos_reg  <= pos_reg + 3'd4;
                        sum_reg  <= sum_add;
                        pcnt_reg <= pcnt_reg + 1'b1;
                    end else begin
                        // gap = sum / pulses by repeated subtraction (sum < 2*pulses+D)
                        pos_reg  <= pos_reg + 3'd4;
                        sum_reg  <= sum_add;
                        gap_reg  <= '0;
                        gsub_reg <= 2'd1;
                    end
                end else begin
                    if (sum_reg >= SW'(pulses_reg)) begin
                        sum_reg <= sum_reg - SW'(pulses_reg);
                        gap_reg <= gap_reg + 1'b1;
                        pos_reg <= pos_reg + 2'd2;
                    end else begin
                        gsub_reg <= 2'd0;
                        pcnt_reg <= pcnt_reg + 1'b1;
                    end
                end
            end else begin
                if (odd_reg && (n_reg - {pulses_reg, 1'b0}) == DW'(1)
                    && gap_reg <= GW'(PB - 2)) begin
                    work_reg <= set_bit(set_bit(work_reg, (PW+1)'(PB - 2) - (PW+1)'(gap_reg)),
                                (PW+1)'(PB - 1) - (PW+1)'(gap_reg));
                end
                pat_fin_reg <= 1'b1;
            end
        end
        if (cmd.ch_next) begin
            ch_reg <= ch_reg + 1'b1;
        end
    end

endmodule

@@ src/burst_fire_ssr_pattern_controller_core.sv @@
// Top level of the burst-fire relay pattern controller.
// Usage:
//   s_axis carries commands: tuser = command[1:0], tdata = power_request[19:0]
//   in 24 bits.
//   set_power spreads the request over the channels and builds the pending
//   pulse patterns; on starts the output, off clears it. Only tick transfers
//   give a result on m_axis: channel_levels in tdata[3:0], cycle_position in
//   tdata[9:4].
//   Sequencing: a tick result is registered and valid in the cycle after
//   acceptance; on, off and tick do not use the allocation sequencer. A
//   set_power transfer occupies it, stepping each fitting or idle channel
//   through ST_CH, ST_DIV and ST_NEXT; the partial channel also runs the
//   serial divider, the accumulator correction and the pattern builder,
//   which sets one pulse or takes one gap step at a time.
//   Reset (aresetn low, synchronous) clears patterns, counters and the
//   accumulator; channel_count returns to 1.
//   A stalled m_axis holds the result; s_axis_tready drops while a result
//   waits or the sequencer is busy.
//   Configuration: cfg_wr_en with cfg_wr_index 0 (channel_count) or 1..4
//   (channel powers) and cfg_wr_data, taken while cfg_wr_en is high.
`timescale 1ns / 1ps
module burst_fire_ssr_pattern_controller_core #(
    parameter int HALF_PERIODS_PER_CYCLE = 32,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // power_request[19:0]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // channel_levels[3:0], cycle_position[9:4]
);
    import bfssr_pkg::*;

    bfssr_cmd_t cmd;
    bfssr_sts_t sts;
    logic busy, go, mval_reg;
    logic [3:0] lev;
    logic [5:0] pos;

    assign s_axis_tready = !busy && !mval_reg;
    assign go = s_axis_tvalid && s_axis_tready;

    bfssr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .go(go && s_axis_tuser == CMD_SET_POWER),
        .busy(busy), .cmd(cmd), .sts(sts)
    );

    bfssr_datapath #(
        .HALF_PERIODS_PER_CYCLE(HALF_PERIODS_PER_CYCLE),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .item_go(go), .item_command(s_axis_tuser),
        .item_power_request(s_axis_tdata[19:0]),
        .cmd(cmd), .sts(sts), .tick_levels(lev), .tick_position(pos)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (go && s_axis_tuser == CMD_TICK) begin
            mval_reg <= 1'b1;
        end else if (m_axis_tready) begin
            mval_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = {6'b0, pos, lev};

endmodule
